@@ design/wma_pkg.sv @@
package wma_pkg;

  // default geometry
  localparam int DEFAULT_MAX_WINDOW  = 64;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  // window length register
  localparam int        CFG_W        = 7;
  localparam logic [6:0] WINDOW_RESET = 7'd8;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_RUN,
    BACK_FINISH
  } back_state_t;

endpackage

@@ design/wma_front.sv @@
module wma_front #(
  parameter int MAX_WINDOW  = wma_pkg::DEFAULT_MAX_WINDOW,
  parameter int SAMPLE_BITS = wma_pkg::DEFAULT_SAMPLE_BITS,
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int CNT_W = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW),
  localparam int ENT_W = SUM_W + CNT_W + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [wma_pkg::CFG_W-1:0] cfg_data,
  input  logic                     push,
  output logic                     full,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [ENT_W-1:0]         q_data
);

  wma_pkg::front_state_t state, state_next;

  logic [wma_pkg::CFG_W-1:0] window_length;
  logic [SUM_W-1:0]          running_sum, running_sum_next;
  logic [CNT_W-1:0]          fill_count, fill_count_next;
  logic [PTR_W-1:0]          write_slot;
  logic [SAMPLE_BITS-1:0]    ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]    oldest_sample;
  logic [SAMPLE_BITS-1:0]    new_sample;
  logic                      drop;
  logic [CNT_W-1:0]          len;
  logic [PTR_W:0]            oldest_raw;
  logic [PTR_W-1:0]          oldest_slot;
  logic [SUM_W-1:0]          add_term, sub_term;
  logic                      accept;

  // effective window length: zero counts as one, clamp at the ring size
  always_comb begin
    if (window_length == '0) begin
      len = CNT_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(window_length);
    end
  end

  // slot of the sample that leaves a full window
  always_comb begin
    oldest_raw = (PTR_W + 1)'(write_slot) + (PTR_W + 1)'(MAX_WINDOW) - (PTR_W + 1)'(len);
    if (oldest_raw >= (PTR_W + 1)'(MAX_WINDOW)) begin
      oldest_raw = oldest_raw - (PTR_W + 1)'(MAX_WINDOW);
    end
    oldest_slot = oldest_raw[PTR_W-1:0];
  end

  assign full   = (state != wma_pkg::FRONT_IDLE) || q_full;
  assign accept = push && !full;

  // sample ring, old entry read before the new one lands
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_slot] <= sample;
      oldest_sample    <= ring[oldest_slot];
      new_sample       <= sample;
      drop             <= (fill_count >= len);
    end
  end

  // running sum and fill level update
  always_comb begin
    add_term = {{(SUM_W - SAMPLE_BITS){new_sample[SAMPLE_BITS-1]}}, new_sample};
    sub_term = drop ? {{(SUM_W - SAMPLE_BITS){oldest_sample[SAMPLE_BITS-1]}}, oldest_sample}
                    : '0;
    running_sum_next = running_sum + add_term - sub_term;
    fill_count_next  = drop ? len : fill_count + CNT_W'(1);
  end

  // next state and queue push
  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    unique case (state)
      wma_pkg::FRONT_IDLE: begin
        if (accept) begin
          state_next = wma_pkg::FRONT_UPDATE;
        end
      end
      wma_pkg::FRONT_UPDATE: begin
        q_push     = 1'b1;
        state_next = wma_pkg::FRONT_IDLE;
      end
      default: begin
        state_next = wma_pkg::FRONT_IDLE;
      end
    endcase
  end

  assign q_data = {running_sum_next, fill_count_next, fill_count_next == len};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wma_pkg::FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window state, emptied on any length write
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= wma_pkg::WINDOW_RESET;
      running_sum   <= '0;
      fill_count    <= '0;
      write_slot    <= '0;
    end else if (cfg_write) begin
      window_length <= cfg_data;
      running_sum   <= '0;
      fill_count    <= '0;
      write_slot    <= '0;
    end else if (q_push) begin
      running_sum <= running_sum_next;
      fill_count  <= fill_count_next;
      if (write_slot == PTR_W'(MAX_WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + PTR_W'(1);
      end
    end
  end

endmodule

@@ design/wma_queue.sv @@
module wma_queue #(
  parameter int WIDTH = 8,
  localparam int DEPTH = wma_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  // item storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ design/wma_back.sv @@
module wma_back #(
  parameter int MAX_WINDOW  = wma_pkg::DEFAULT_MAX_WINDOW,
  parameter int SAMPLE_BITS = wma_pkg::DEFAULT_SAMPLE_BITS,
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW),
  localparam int ENT_W  = SUM_W + CNT_W + 1,
  localparam int STEP_W = $clog2(SUM_W)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  logic [ENT_W-1:0]       q_data,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic [SAMPLE_BITS-1:0] average,
  output logic                   window_full
);

  wma_pkg::back_state_t state, state_next;

  logic [SUM_W-1:0]  in_sum;
  logic [CNT_W-1:0]  in_count;
  logic              in_full;
  logic [SUM_W-1:0]  dividend;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W-1:0]  remainder;
  logic [CNT_W:0]    rem_shift;
  logic              fits;
  logic [STEP_W-1:0] step;
  logic              negative;
  logic              held_full;
  logic              out_valid;
  logic              load_out;

  assign {in_sum, in_count, in_full} = q_data;

  // one quotient bit per cycle, restoring form
  assign rem_shift = {remainder, dividend[SUM_W-1]};
  assign fits      = (rem_shift >= {1'b0, divisor});

  assign empty = !out_valid;

  // next state, queue pop and output load
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      wma_pkg::BACK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = wma_pkg::BACK_RUN;
        end
      end
      wma_pkg::BACK_RUN: begin
        if (step == '0) begin
          state_next = wma_pkg::BACK_FINISH;
        end
      end
      wma_pkg::BACK_FINISH: begin
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = wma_pkg::BACK_IDLE;
        end
      end
      default: begin
        state_next = wma_pkg::BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wma_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      negative  <= in_sum[SUM_W-1];
      dividend  <= in_sum[SUM_W-1] ? (~in_sum + SUM_W'(1)) : in_sum;
      divisor   <= in_count;
      remainder <= '0;
      held_full <= in_full;
      step      <= STEP_W'(SUM_W - 1);
    end else if (state == wma_pkg::BACK_RUN) begin
      remainder <= fits ? CNT_W'(rem_shift - {1'b0, divisor}) : rem_shift[CNT_W-1:0];
      dividend  <= {dividend[SUM_W-2:0], fits};
      step      <= step - STEP_W'(1);
    end
  end

  // result register, sign restored for truncation toward zero
  always_ff @(posedge clk) begin
    if (load_out) begin
      average     <= negative ? (~dividend[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                              : dividend[SAMPLE_BITS-1:0];
      window_full <= held_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/windowed_moving_average.sv @@
// Moving average over the most recent window_length samples.
// Input side is a queue write port: an item (one signed sample) is taken
// at a clock edge with push high and full low.
// Result side is a queue read port: while empty is low, average and
// window_full show the oldest result; it is taken with pop high.
// Each item gives exactly one result, in order.
// window_length_write loads window_length and empties the window; write it
// only while no item is in flight. Zero acts as one, values above MAX_WINDOW
// act as MAX_WINDOW.
// An accepted item passes the front update state and the queue, then the
// divider runs and the result register loads its quotient.
// The back takes a new item only once the last result is loaded; it holds
// the shared bit-serial divider that forms one quotient bit per cycle.
// The front (ring store and running sum) pushes each item into a two-entry
// queue before taking the next, and keeps accepting while the divider works.
// Reset: window empty, window_length 8, no result pending.
// When the receiver stalls the result register holds, the divider waits,
// the queue fills and full rises; nothing is dropped.
module windowed_moving_average #(
  parameter int MAX_WINDOW  = wma_pkg::DEFAULT_MAX_WINDOW,
  parameter int SAMPLE_BITS = wma_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      window_length_write,
  input  logic [wma_pkg::CFG_W-1:0] window_length,
  input  logic                      push,
  output logic                      full,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      empty,
  input  logic                      pop,
  output logic [SAMPLE_BITS-1:0]    average,
  output logic                      window_full
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int ENT_W = SUM_W + CNT_W + 1;

  logic             q_push, q_full, q_pop, q_empty;
  logic [ENT_W-1:0] q_wr_data, q_rd_data;

  // ring store, running sum, fill level
  wma_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (window_length_write),
    .cfg_data  (window_length),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  // sum and count waiting for the divider
  wma_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // serial divide and result register
  wma_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .average     (average),
    .window_full (window_full)
  );

endmodule
